>>> rtl/acfb_pkg.sv
package acfb_pkg;

  // input field widths
  localparam int unsigned ModeW    = 4;
  localparam int unsigned ScratchW = 32;

  // output field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ReplyW = 4;

  // frame geometry
  localparam int unsigned MaxBytes = 9;
  localparam int unsigned CountW   = 4;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;

  localparam logic [CfgIdxW-1:0] REG_TX_MODE      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BEAM_MODE    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_THETA_ANGLE  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PHI_ANGLE    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FREQUENCY    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_BEAM_ENABLE  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_FACTORY_FLAG = 3'd6;

  // register widths
  localparam int unsigned ThetaW = 15;
  localparam int unsigned PhiW   = 17;
  localparam int unsigned FreqW  = 15;

  localparam logic [FreqW-1:0] FREQ_MIN = 15'd27500;
  localparam logic [FreqW-1:0] FREQ_MAX = 15'd30000;

  // command codes on the input
  localparam logic [ModeW-1:0] MODE_SET_SCRATCH  = 4'd0;
  localparam logic [ModeW-1:0] MODE_READ_SCRATCH = 4'd1;
  localparam logic [ModeW-1:0] MODE_FIXED_SEQ    = 4'd2;
  localparam logic [ModeW-1:0] MODE_POINTING     = 4'd3;
  localparam logic [ModeW-1:0] MODE_ARRAY_CFG    = 4'd4;
  localparam logic [ModeW-1:0] MODE_FACTORY_RST  = 4'd5;
  localparam logic [ModeW-1:0] MODE_ENABLE_BEAM  = 4'd6;
  localparam logic [ModeW-1:0] MODE_STATUS_SUM   = 4'd7;
  localparam logic [ModeW-1:0] MODE_STATUS_DET   = 4'd8;

  // header bytes
  localparam logic [ByteW-1:0] HDR_SET_SCRATCH  = 8'h81;
  localparam logic [ByteW-1:0] HDR_READ_SCRATCH = 8'h82;
  localparam logic [ByteW-1:0] HDR_FIXED_SEQ    = 8'h83;
  localparam logic [ByteW-1:0] HDR_POINTING     = 8'hA0;
  localparam logic [ByteW-1:0] HDR_ARRAY_CFG    = 8'hB1;
  localparam logic [ByteW-1:0] HDR_FACTORY_RST  = 8'hC0;
  localparam logic [ByteW-1:0] HDR_ENABLE_BEAM  = 8'hE0;
  localparam logic [ByteW-1:0] HDR_STATUS_SUM   = 8'hF0;
  localparam logic [ByteW-1:0] HDR_STATUS_DET   = 8'hF1;

  localparam logic [ByteW-1:0] RESET_KEY_HI = 8'hBA;
  localparam logic [ByteW-1:0] RESET_KEY_LO = 8'h11;

  // expected reply lengths
  localparam logic [ReplyW-1:0] REPLY_DEFAULT    = 4'd6;
  localparam logic [ReplyW-1:0] REPLY_ARRAY_CFG  = 4'd10;
  localparam logic [ReplyW-1:0] REPLY_STATUS_SUM = 4'd3;
  localparam logic [ReplyW-1:0] REPLY_STATUS_DET = 4'd14;

  // angle scaling: a * 65535 / (2^s * 45), done as (a * 65535) >> s, then
  // a multiply by ceil(2^28 / 45) and >> 28 (exact for 22-bit operands)
  localparam int unsigned ScaledW  = 22;
  localparam int unsigned RecipW   = 23;
  localparam int unsigned RecipSh  = 28;
  localparam int unsigned ProdW    = ScaledW + RecipW;
  localparam int unsigned QuotW    = ProdW - RecipSh;
  localparam int unsigned AngleW   = 16;
  localparam logic [RecipW-1:0] RECIP_45 = 23'd5965233;
  localparam int unsigned ThetaSh = 9;
  localparam int unsigned PhiSh   = 11;
  localparam logic [AngleW-1:0] FULL16 = 16'hFFFF;

endpackage

>>> rtl/antenna_command_frame_builder.sv
// Command frame builder for an antenna array serial link.
// Input stream (s_axis): one command per transaction; tuser carries the
// command kind, tdata the 32-bit scratch value used by the set-scratch command.
// Output stream (m_axis): one frame byte per transaction, tlast on the XOR
// checksum byte that closes the frame, and the expected reply length beside it.
// Configuration channel: cfg_valid_i/cfg_ready_o with a register index and
// data; always ready. Write only while no frame is in flight.
// The pipeline has three stages: angle prescale, reciprocal multiply, and
// frame build/serialize. A command passes through the stage 1 and stage 2
// registers before it is loaded into the stage 3 serializer as a frame.
// A frame of n bytes (2 to 9, header + payload + checksum) holds the output
// serializer until its last byte is taken, and the next frame is loaded as
// that byte is taken; up to two more commands wait in the earlier stages.
// Unknown command kinds are dropped in the last stage and produce no bytes.
// Reset clears all pipeline valid bits and returns the registers to their
// defaults (frequency 27500, everything else zero).
// When the receiver deasserts m_axis_tready, the current byte is held and the
// stall propagates back stage by stage to s_axis_tready; nothing is lost.
module antenna_command_frame_builder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [acfb_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [acfb_pkg::CfgDataW-1:0]       cfg_data_i,
  // command input
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [acfb_pkg::ScratchW-1:0]       s_axis_tdata,  // [31:0] scratch_value
  input  logic [acfb_pkg::ModeW-1:0]          s_axis_tuser,  // [3:0] mode
  // frame byte output
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [15:0]                         m_axis_tdata,  // [7:0] frame_byte,
                                                             // [11:8] reply_length, rest 0
  output logic                                m_axis_tlast   // last_byte
);

  // configuration registers
  logic                             tx_mode_q;
  logic [1:0]                       beam_mode_q;
  logic [acfb_pkg::ThetaW-1:0]      theta_q;
  logic [acfb_pkg::PhiW-1:0]        phi_q;
  logic [acfb_pkg::FreqW-1:0]       freq_q;
  logic                             beam_en_q;
  logic                             factory_q;
  logic [acfb_pkg::FreqW-1:0]       freq_d;

  // stage 1
  logic                             v1_q;
  logic [acfb_pkg::ModeW-1:0]       mode1_q;
  logic [acfb_pkg::ScratchW-1:0]    scratch1_q;
  logic [acfb_pkg::ScaledW-1:0]     xth1_q, xph1_q, xth1_d, xph1_d;
  logic [acfb_pkg::ThetaW+15:0]     pth;
  logic [acfb_pkg::PhiW+15:0]       pph;

  // stage 2
  logic                             v2_q;
  logic [acfb_pkg::ModeW-1:0]       mode2_q;
  logic [acfb_pkg::ScratchW-1:0]    scratch2_q;
  logic [acfb_pkg::QuotW-1:0]       qth2_q, qph2_q;
  logic [acfb_pkg::ProdW-1:0]       prod_th, prod_ph;

  // stage 3: frame serializer
  logic                             v3_q, v3_d;
  logic [acfb_pkg::ByteW-1:0]       bytes_q [acfb_pkg::MaxBytes];
  logic [acfb_pkg::ByteW-1:0]       bytes_d [acfb_pkg::MaxBytes];
  logic [acfb_pkg::CountW-1:0]      rem_q, rem_d;
  logic [acfb_pkg::ReplyW-1:0]      reply_q, reply_d;

  // frame build
  logic [acfb_pkg::ByteW-1:0]       pay [acfb_pkg::MaxBytes];
  logic [acfb_pkg::CountW-1:0]      plen;
  logic [acfb_pkg::ReplyW-1:0]      reply;
  logic                             known;
  logic [acfb_pkg::ByteW-1:0]       csum;
  logic [acfb_pkg::AngleW-1:0]      th16, ph16;

  logic en1, en2, en3, out_fire, out_last;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    freq_d = cfg_data_i[acfb_pkg::FreqW-1:0];
    if (freq_d > acfb_pkg::FREQ_MAX) begin
      freq_d = acfb_pkg::FREQ_MAX;
    end else if (freq_d < acfb_pkg::FREQ_MIN) begin
      freq_d = acfb_pkg::FREQ_MIN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_mode_q   <= 1'b0;
      beam_mode_q <= '0;
      theta_q     <= '0;
      phi_q       <= '0;
      freq_q      <= acfb_pkg::FREQ_MIN;
      beam_en_q   <= 1'b0;
      factory_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        acfb_pkg::REG_TX_MODE:      tx_mode_q   <= cfg_data_i[0];
        acfb_pkg::REG_BEAM_MODE:    beam_mode_q <= cfg_data_i[1:0];
        acfb_pkg::REG_THETA_ANGLE:  theta_q     <= cfg_data_i[acfb_pkg::ThetaW-1:0];
        acfb_pkg::REG_PHI_ANGLE:    phi_q       <= cfg_data_i[acfb_pkg::PhiW-1:0];
        acfb_pkg::REG_FREQUENCY:    freq_q      <= freq_d;
        acfb_pkg::REG_BEAM_ENABLE:  beam_en_q   <= cfg_data_i[0];
        acfb_pkg::REG_FACTORY_FLAG: factory_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // handshake / stall chain
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign out_last      = (rem_q == acfb_pkg::CountW'(1));
  assign en3           = !v3_q || (out_fire && out_last);
  assign en2           = !v2_q || en3;
  assign en1           = !v1_q || en2;
  assign s_axis_tready = en1;

  // stage 1: a * 65535 = (a << 16) - a, then drop the power-of-two divisor
  assign pth    = {theta_q, 16'h0000} - (acfb_pkg::ThetaW + 16)'(theta_q);
  assign pph    = {phi_q, 16'h0000} - (acfb_pkg::PhiW + 16)'(phi_q);
  assign xth1_d = pth[acfb_pkg::ThetaSh +: acfb_pkg::ScaledW];
  assign xph1_d = pph[acfb_pkg::PhiSh +: acfb_pkg::ScaledW];

  // stage 2: divide by 45 via reciprocal
  assign prod_th = acfb_pkg::ProdW'(xth1_q) * acfb_pkg::ProdW'(acfb_pkg::RECIP_45);
  assign prod_ph = acfb_pkg::ProdW'(xph1_q) * acfb_pkg::ProdW'(acfb_pkg::RECIP_45);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      v3_q <= v3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      mode1_q    <= s_axis_tuser;
      scratch1_q <= s_axis_tdata;
      xth1_q     <= xth1_d;
      xph1_q     <= xph1_d;
    end
    if (en2) begin
      mode2_q    <= mode1_q;
      scratch2_q <= scratch1_q;
      qth2_q     <= prod_th[acfb_pkg::ProdW-1:acfb_pkg::RecipSh];
      qph2_q     <= prod_ph[acfb_pkg::ProdW-1:acfb_pkg::RecipSh];
    end
    bytes_q <= bytes_d;
    rem_q   <= rem_d;
    reply_q <= reply_d;
  end

  // stage 3: saturate angles, build frame and checksum
  assign th16 = (qth2_q > acfb_pkg::QuotW'(acfb_pkg::FULL16)) ?
                acfb_pkg::FULL16 : qth2_q[acfb_pkg::AngleW-1:0];
  assign ph16 = (qph2_q > acfb_pkg::QuotW'(acfb_pkg::FULL16)) ?
                acfb_pkg::FULL16 : qph2_q[acfb_pkg::AngleW-1:0];

  always_comb begin
    for (int i = 0; i < acfb_pkg::MaxBytes; i++) pay[i] = '0;
    plen  = acfb_pkg::CountW'(1);
    reply = acfb_pkg::REPLY_DEFAULT;
    known = 1'b1;
    case (mode2_q)
      acfb_pkg::MODE_SET_SCRATCH: begin
        pay[0] = acfb_pkg::HDR_SET_SCRATCH;
        pay[1] = scratch2_q[31:24];
        pay[2] = scratch2_q[23:16];
        pay[3] = scratch2_q[15:8];
        pay[4] = scratch2_q[7:0];
        plen   = acfb_pkg::CountW'(5);
      end
      acfb_pkg::MODE_READ_SCRATCH: pay[0] = acfb_pkg::HDR_READ_SCRATCH;
      acfb_pkg::MODE_FIXED_SEQ:    pay[0] = acfb_pkg::HDR_FIXED_SEQ;
      acfb_pkg::MODE_POINTING: begin
        pay[0] = acfb_pkg::HDR_POINTING;
        pay[1] = {5'b00000, tx_mode_q, beam_mode_q};
        pay[2] = th16[15:8];
        pay[3] = th16[7:0];
        pay[4] = ph16[15:8];
        pay[5] = ph16[7:0];
        pay[6] = {1'b0, freq_q[14:8]};
        pay[7] = freq_q[7:0];
        plen   = acfb_pkg::CountW'(8);
      end
      acfb_pkg::MODE_ARRAY_CFG: begin
        pay[0] = acfb_pkg::HDR_ARRAY_CFG;
        reply  = acfb_pkg::REPLY_ARRAY_CFG;
      end
      acfb_pkg::MODE_FACTORY_RST: begin
        pay[0] = acfb_pkg::HDR_FACTORY_RST;
        pay[1] = factory_q ? acfb_pkg::RESET_KEY_HI : 8'h00;
        pay[2] = factory_q ? acfb_pkg::RESET_KEY_LO : 8'h00;
        plen   = acfb_pkg::CountW'(3);
      end
      acfb_pkg::MODE_ENABLE_BEAM: begin
        pay[0] = acfb_pkg::HDR_ENABLE_BEAM;
        pay[1] = {7'b0000000, beam_en_q};
        plen   = acfb_pkg::CountW'(2);
      end
      acfb_pkg::MODE_STATUS_SUM: begin
        pay[0] = acfb_pkg::HDR_STATUS_SUM;
        reply  = acfb_pkg::REPLY_STATUS_SUM;
      end
      acfb_pkg::MODE_STATUS_DET: begin
        pay[0] = acfb_pkg::HDR_STATUS_DET;
        reply  = acfb_pkg::REPLY_STATUS_DET;
      end
      default: known = 1'b0;
    endcase

    // unused slots are zero, so XOR over all of them is the frame checksum
    csum = '0;
    for (int i = 0; i < acfb_pkg::MaxBytes; i++) csum = csum ^ pay[i];
  end

  // serializer: load a new frame or shift out one byte per transaction
  always_comb begin
    v3_d    = v3_q;
    bytes_d = bytes_q;
    rem_d   = rem_q;
    reply_d = reply_q;
    if (en3) begin
      v3_d    = v2_q && known;
      rem_d   = plen + acfb_pkg::CountW'(1);
      reply_d = reply;
      for (int i = 0; i < acfb_pkg::MaxBytes; i++) begin
        bytes_d[i] = (acfb_pkg::CountW'(i) == plen) ? csum : pay[i];
      end
    end else if (out_fire) begin
      rem_d = rem_q - acfb_pkg::CountW'(1);
      for (int i = 0; i < acfb_pkg::MaxBytes - 1; i++) bytes_d[i] = bytes_q[i+1];
      bytes_d[acfb_pkg::MaxBytes-1] = '0;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {4'h0, reply_q, bytes_q[0]};

endmodule
